[hw/rtl/sdq_pkg.sv]
// Shared types, codes and sizing constants for the searchable deque.
package sdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int CHUNK     = 16;
    localparam int CHUNK_IW  = 4;
    localparam int WORD_W    = 32;

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd1;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_FIND       = 3'd4;
    localparam logic [2:0] MODE_SIZE       = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] data;
        logic               found;
        logic [3:0]         position;
        logic [4:0]         count;
        logic [1:0]         status;
    } t_rsp;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic append;
    } t_cell_ctl;

endpackage

[hw/rtl/sdq_cell.sv]
// One storage cell of the deque chain: holds one word, shifts with its neighbors.
module sdq_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                        i_clk,
    input  sdq_pkg::t_cell_ctl          i_ctl,
    input  logic [sdq_pkg::WORD_W-1:0]  i_key,
    input  logic [sdq_pkg::WORD_W-1:0]  i_left,
    input  logic [sdq_pkg::WORD_W-1:0]  i_right,
    input  logic [CW-1:0]               i_count,
    output logic [sdq_pkg::WORD_W-1:0]  o_data,
    output logic                        o_hit,
    output logic [sdq_pkg::WORD_W-1:0]  o_tail
);

    logic [sdq_pkg::WORD_W-1:0] r_data;
    logic [sdq_pkg::WORD_W-1:0] n_data;
    logic                       occupied;
    logic                       is_tail;

    assign occupied = CW'(INDEX) < i_count;
    assign is_tail  = CW'(INDEX + 1) == i_count;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            n_data = i_left;
        end else if (i_ctl.shift_down) begin
            n_data = i_right;
        end else if (i_ctl.append && (CW'(INDEX) == i_count)) begin
            n_data = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = occupied && (r_data == i_key);
    assign o_tail = is_tail ? r_data : '0;

endmodule

[hw/rtl/sdq_chunk.sv]
// First stage of the search tree: lowest hit and tail word over one group of cells.
module sdq_chunk (
    input  logic                                          i_clk,
    input  logic [sdq_pkg::CHUNK-1:0]                     i_hit,
    input  logic [sdq_pkg::CHUNK-1:0][sdq_pkg::WORD_W-1:0] i_tail,
    output logic                                          o_any,
    output logic [sdq_pkg::CHUNK_IW-1:0]                  o_idx,
    output logic [sdq_pkg::WORD_W-1:0]                    o_tail
);

    logic                          r_any;
    logic [sdq_pkg::CHUNK_IW-1:0]  r_idx;
    logic [sdq_pkg::WORD_W-1:0]    r_tail;
    logic [sdq_pkg::CHUNK_IW-1:0]  n_idx;
    logic [sdq_pkg::WORD_W-1:0]    n_tail;

    // lowest set bit wins: scan from the top down
    always_comb begin
        n_idx  = '0;
        n_tail = '0;
        for (int j = sdq_pkg::CHUNK - 1; j >= 0; j--) begin
            if (i_hit[j]) begin
                n_idx = sdq_pkg::CHUNK_IW'(j);
            end
            n_tail = n_tail | i_tail[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_any  <= |i_hit;
        r_idx  <= n_idx;
        r_tail <= n_tail;
    end

    assign o_any  = r_any;
    assign o_idx  = r_idx;
    assign o_tail = r_tail;

endmodule

[hw/rtl/searchable_deque.sv]
// Top level of the searchable deque: cell chain, search tree and result register.
//
// Usage:
//   Drive i_cmd (mode, value) and raise start; the transfer happens at the
//   rising edge where start is high and busy is low. Each command gives
//   exactly one result on o_rsp, marked by o_valid for one cycle.
//   Push front/back, pop front, size, the undecoded modes and any pop from an
//   empty list: the result shows in the cycle after the transfer and busy
//   stays low, so one command per cycle is taken while no search is pending.
//   Find and a pop back from a non-empty list: every cell compares or masks
//   its word in the transfer cycle, a group stage per 16 cells registers the
//   lowest hit and the tail word, and a final stage over the groups fills
//   the result register. Busy is high while the group stage holds the search,
//   so no new command is taken until the result register is filled.
//   Contents shift by one cell on each push front / pop front; push
//   back writes the cell at the count, pop back only lowers the count.
//   Reset (synchronous, active low) empties the list and drops any pending
//   result; cell contents are not cleared and are never read before written.
//   The receiver cannot stall: every result is taken in its strobe cycle.
module searchable_deque #(
    parameter int DEPTH = sdq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sdq_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output sdq_pkg::t_rsp o_rsp
);

    localparam int CW     = $clog2(DEPTH + 1);
    localparam int NCHUNK = (DEPTH + sdq_pkg::CHUNK - 1) / sdq_pkg::CHUNK;
    localparam int PADN   = NCHUNK * sdq_pkg::CHUNK;
    localparam int PPW    = $clog2(PADN);

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_pend;
    logic                    r_pend_find;
    logic                    r_valid;
    sdq_pkg::t_rsp           r_rsp;
    sdq_pkg::t_rsp           n_rsp;
    logic                    n_valid;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    is_pf;
    logic                    is_ppf;
    logic                    is_pb;
    logic                    is_ppb;
    logic                    is_find;
    logic                    defer;
    sdq_pkg::t_cell_ctl      ctl;

    logic [DEPTH-1:0][sdq_pkg::WORD_W-1:0] cell_data;
    logic [PADN-1:0]                       hit_vec;
    logic [PADN-1:0][sdq_pkg::WORD_W-1:0]  tail_vec;

    logic [NCHUNK-1:0]                            grp_any;
    logic [NCHUNK-1:0][sdq_pkg::CHUNK_IW-1:0]     grp_idx;
    logic [NCHUNK-1:0][sdq_pkg::WORD_W-1:0]       grp_tail;

    logic                        tree_found;
    logic [PPW-1:0]              tree_pos;
    logic [sdq_pkg::WORD_W-1:0]  tree_tail;

    // Decode the command
    assign accept  = start && !busy;
    assign full    = r_count == CW'(DEPTH);
    assign empty   = r_count == '0;
    assign is_pf   = i_cmd.mode == sdq_pkg::MODE_PUSH_FRONT;
    assign is_ppf  = i_cmd.mode == sdq_pkg::MODE_POP_FRONT;
    assign is_pb   = i_cmd.mode == sdq_pkg::MODE_PUSH_BACK;
    assign is_ppb  = i_cmd.mode == sdq_pkg::MODE_POP_BACK;
    assign is_find = i_cmd.mode == sdq_pkg::MODE_FIND;

    // Find and a real pop back wait for the search tree
    assign defer = accept && (is_find || (is_ppb && !empty));

    assign ctl.shift_up   = accept && is_pf && !full;
    assign ctl.shift_down = accept && is_ppf && !empty;
    assign ctl.append     = accept && is_pb && !full;

    always_comb begin
        n_count = r_count;
        if (ctl.shift_up || ctl.append) begin
            n_count = r_count + CW'(1);
        end else if (ctl.shift_down || (accept && is_ppb && !empty)) begin
            n_count = r_count - CW'(1);
        end
    end

    // Cell chain: front at cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [sdq_pkg::WORD_W-1:0] left;
        logic [sdq_pkg::WORD_W-1:0] right;

        if (i == 0) begin : g_first
            assign left = i_cmd.value;
        end else begin : g_mid
            assign left = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right = cell_data[i];
        end else begin : g_inner
            assign right = cell_data[i+1];
        end

        sdq_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_key   (i_cmd.value),
            .i_left  (left),
            .i_right (right),
            .i_count (r_count),
            .o_data  (cell_data[i]),
            .o_hit   (hit_vec[i]),
            .o_tail  (tail_vec[i])
        );
    end

    // Pad the last group with empty slots
    for (genvar i = DEPTH; i < PADN; i++) begin : g_pad
        assign hit_vec[i]  = 1'b0;
        assign tail_vec[i] = '0;
    end

    for (genvar k = 0; k < NCHUNK; k++) begin : g_grp
        sdq_chunk u_chunk (
            .i_clk  (i_clk),
            .i_hit  (hit_vec[k*sdq_pkg::CHUNK +: sdq_pkg::CHUNK]),
            .i_tail (tail_vec[k*sdq_pkg::CHUNK +: sdq_pkg::CHUNK]),
            .o_any  (grp_any[k]),
            .o_idx  (grp_idx[k]),
            .o_tail (grp_tail[k])
        );
    end

    // Final stage: lowest group with a hit, OR of the tail words
    always_comb begin
        tree_found = |grp_any;
        tree_pos   = '0;
        tree_tail  = '0;
        for (int k = NCHUNK - 1; k >= 0; k--) begin
            if (grp_any[k]) begin
                tree_pos = PPW'(k * sdq_pkg::CHUNK) + PPW'(grp_idx[k]);
            end
            tree_tail = tree_tail | grp_tail[k];
        end
    end

    // Result select: the pending search result, else the direct one
    always_comb begin
        n_rsp   = r_rsp;
        n_valid = 1'b0;
        if (r_pend) begin
            n_valid        = 1'b1;
            n_rsp.data     = r_pend_find ? '0 : tree_tail;
            n_rsp.found    = r_pend_find && tree_found;
            n_rsp.position = (r_pend_find && tree_found) ? tree_pos[3:0] : 4'd0;
            n_rsp.count    = 5'(r_count);
            n_rsp.status   = sdq_pkg::ST_OK;
        end else if (accept && !defer) begin
            n_valid        = 1'b1;
            n_rsp.data     = ctl.shift_down ? cell_data[0] : '0;
            n_rsp.found    = 1'b0;
            n_rsp.position = 4'd0;
            n_rsp.count    = 5'(n_count);
            n_rsp.status   = sdq_pkg::ST_OK;
            if ((is_pf || is_pb) && full) begin
                n_rsp.status = sdq_pkg::ST_FULL;
            end else if ((is_ppf || is_ppb) && empty) begin
                n_rsp.status = sdq_pkg::ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= defer;
            r_valid <= n_valid;
        end
    end

    // Hold the payload; no reset needed
    always_ff @(posedge i_clk) begin
        r_rsp       <= n_rsp;
        r_pend_find <= is_find;
    end

    assign busy    = r_pend;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef ASSERT_OFF
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> !r_pend)
        else $error("busy held for more than one cycle");

    a_pend_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_valid)
        else $error("pending search produced no result");

    a_direct_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !defer) |=> r_valid)
        else $error("transfer produced no result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count beyond depth");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rsp.status == sdq_pkg::ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status while not full");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rsp.found) |-> (r_rsp.status == sdq_pkg::ST_OK))
        else $error("found with non-ok status");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the searchable deque: directed corners, then random op bursts.
module tb;

    localparam int DEQ_DEPTH = sdq_pkg::DEPTH_DEF;

    // Modes six and seven are not decoded by the block; they must act like a size query.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int RANDOM_OPS = 700;

    // Shadow copy of the list plus the queue of responses it predicts, in issue order.
    class deque_scoreboard;
        logic signed [31:0] cells [DEQ_DEPTH];
        int unsigned        held;
        sdq_pkg::t_rsp      rsp_q [$];
        int unsigned        errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int pending();
            return rsp_q.size();
        endfunction

        // Return a word that is currently in the list, or a random word when empty.
        function logic [31:0] held_word();
            if (held == 0) begin
                return $urandom();
            end
            return cells[$urandom_range(held - 1)];
        endfunction

        // Apply one accepted command to the shadow list and queue its response.
        function void note_cmd(sdq_pkg::t_cmd c);
            sdq_pkg::t_rsp r;
            int            i;
            r        = '0;
            r.status = sdq_pkg::ST_OK;
            case (c.mode)
                sdq_pkg::MODE_PUSH_FRONT: begin
                    if (held >= DEQ_DEPTH) begin
                        r.status = sdq_pkg::ST_FULL;
                    end else begin
                        for (i = held; i > 0; i--) cells[i] = cells[i - 1];
                        cells[0] = c.value;
                        held++;
                    end
                end
                sdq_pkg::MODE_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = sdq_pkg::ST_EMPTY;
                    end else begin
                        r.data = cells[0];
                        held--;
                        for (i = 0; i < held; i++) cells[i] = cells[i + 1];
                    end
                end
                sdq_pkg::MODE_PUSH_BACK: begin
                    if (held >= DEQ_DEPTH) begin
                        r.status = sdq_pkg::ST_FULL;
                    end else begin
                        cells[held] = c.value;
                        held++;
                    end
                end
                sdq_pkg::MODE_POP_BACK: begin
                    if (held == 0) begin
                        r.status = sdq_pkg::ST_EMPTY;
                    end else begin
                        held--;
                        r.data = cells[held];
                    end
                end
                sdq_pkg::MODE_FIND: begin
                    // lowest matching index wins
                    for (i = held - 1; i >= 0; i--) begin
                        if (cells[i] == c.value) begin
                            r.found    = 1'b1;
                            r.position = 4'(i);
                        end
                    end
                end
                default: ;
            endcase
            r.count = 5'(held);
            rsp_q = {rsp_q, r};
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("%0t ns: %s mismatch, got %0h want %0h", $time, field, got, want);
        endtask

        // Compare one response with the oldest prediction, field by field.
        task check_rsp(sdq_pkg::t_rsp got);
            sdq_pkg::t_rsp want;
            if (rsp_q.size() == 0) begin
                report("unexpected response data", got.data, 32'd0);
                return;
            end
            want = rsp_q[0];
            rsp_q.delete(0);
            if (got.data !== want.data)         report("data", got.data, want.data);
            if (got.found !== want.found)       report("found", got.found, want.found);
            if (got.position !== want.position) report("position", got.position, want.position);
            if (got.count !== want.count)       report("count", got.count, want.count);
            if (got.status !== want.status)     report("status", got.status, want.status);
        endtask
    endclass

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    sdq_pkg::t_cmd i_cmd   = '0;
    logic          o_valid;
    sdq_pkg::t_rsp o_rsp;

    deque_scoreboard sb = new();

    bit          idle_on = 1'b1;
    int unsigned sent    = 0;

    searchable_deque #(
        .DEPTH(DEQ_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_cmd  (i_cmd),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Fixed run limit; far above the slowest legal run.
    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // The receiver never stalls: take every strobed response at the edge that ends it.
    always @(posedge i_clk) begin
        if (o_valid === 1'b1) begin
            sb.check_rsp(o_rsp);
        end
    end

    // Word source: half from a pool of corner values (so finds hit duplicates), half random.
    function logic [31:0] pick_word();
        if ($urandom_range(1) == 0) begin
            return $urandom();
        end
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h0000_0001;
            5:       return 32'h5555_5555;
            6:       return 32'hAAAA_AAAA;
            default: return 32'h1234_5678;
        endcase
    endfunction

    // Drive one command and hold it until the transfer. Leave start high afterwards so
    // back-to-back commands never drop and raise start within one time step.
    task send(logic [2:0] mode, logic [31:0] value);
        sdq_pkg::t_cmd c;
        c.mode  = mode;
        c.value = value;
        if (idle_on && $urandom_range(99) < 11) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_cmd(c);
        sent++;
    endtask

    // Drop start and hold off until every predicted response has come back.
    task wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Push at random ends until the list is full, push past full, then find a held word.
    task fill_burst();
        while (sb.held < DEQ_DEPTH) begin
            send($urandom_range(1) ? sdq_pkg::MODE_PUSH_BACK : sdq_pkg::MODE_PUSH_FRONT,
                 pick_word());
        end
        repeat ($urandom_range(1, 2)) begin
            send($urandom_range(1) ? sdq_pkg::MODE_PUSH_BACK : sdq_pkg::MODE_PUSH_FRONT,
                 pick_word());
        end
        send(sdq_pkg::MODE_FIND, sb.held_word());
    endtask

    // Pop at random ends until the list is empty, then pop past empty.
    task drain_burst();
        while (sb.held > 0) begin
            send($urandom_range(1) ? sdq_pkg::MODE_POP_BACK : sdq_pkg::MODE_POP_FRONT,
                 $urandom());
        end
        repeat ($urandom_range(1, 2)) begin
            send($urandom_range(1) ? sdq_pkg::MODE_POP_BACK : sdq_pkg::MODE_POP_FRONT,
                 $urandom());
        end
    endtask

    // Mixed traffic; finds mostly look for words that are in the list.
    task mixed_burst();
        int unsigned pick;
        repeat ($urandom_range(8, 20)) begin
            pick = $urandom_range(99);
            if (pick < 15)      send(sdq_pkg::MODE_PUSH_FRONT, pick_word());
            else if (pick < 30) send(sdq_pkg::MODE_PUSH_BACK, pick_word());
            else if (pick < 42) send(sdq_pkg::MODE_POP_FRONT, $urandom());
            else if (pick < 55) send(sdq_pkg::MODE_POP_BACK, $urandom());
            else if (pick < 75) send(sdq_pkg::MODE_FIND, sb.held_word());
            else if (pick < 85) send(sdq_pkg::MODE_FIND, pick_word());
            else if (pick < 93) send(sdq_pkg::MODE_SIZE, $urandom());
            else                send($urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7, $urandom());
        end
    endtask

    initial begin
        // Hold reset at the start, then release it once.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: both pops, find, size and the undecoded modes.
        send(sdq_pkg::MODE_POP_FRONT, 32'h0000_0000);
        send(sdq_pkg::MODE_POP_BACK, 32'hFFFF_FFFF);
        send(sdq_pkg::MODE_FIND, 32'h0000_0000);
        send(sdq_pkg::MODE_SIZE, 32'h0000_0000);
        send(MODE_SPARE_6, 32'hFFFF_FFFF);
        send(MODE_SPARE_7, 32'h8000_0000);
        // Extremes of the word at both ends, with a duplicate to test lowest-index find.
        send(sdq_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF);
        send(sdq_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
        send(sdq_pkg::MODE_PUSH_BACK, 32'h0000_0000);
        send(sdq_pkg::MODE_PUSH_BACK, 32'hFFFF_FFFF);
        send(sdq_pkg::MODE_PUSH_FRONT, 32'h0000_0000);
        send(sdq_pkg::MODE_FIND, 32'h0000_0000);
        send(sdq_pkg::MODE_FIND, 32'hFFFF_FFFF);
        send(sdq_pkg::MODE_FIND, 32'h7FFF_FFFF);
        send(sdq_pkg::MODE_FIND, 32'h1234_5678);
        send(sdq_pkg::MODE_SIZE, 32'h7FFF_FFFF);
        // Unwind from both ends until a pop past empty.
        send(sdq_pkg::MODE_POP_BACK, 32'h0000_0000);
        send(sdq_pkg::MODE_POP_FRONT, 32'h0000_0000);
        send(sdq_pkg::MODE_POP_FRONT, 32'h0000_0000);
        send(sdq_pkg::MODE_POP_BACK, 32'h0000_0000);
        send(sdq_pkg::MODE_POP_BACK, 32'h0000_0000);
        send(sdq_pkg::MODE_POP_FRONT, 32'h0000_0000);

        // Random part: make sure full and empty are hit early, then random bursts.
        sent = 0;
        fill_burst();
        drain_burst();
        while (sent < RANDOM_OPS) begin
            // Run a long stretch back to back with no sender gaps.
            idle_on = !(sent >= 150 && sent < 300);
            case ($urandom_range(9))
                0, 1:    fill_burst();
                2:       drain_burst();
                9: begin
                    repeat (3) send(3'($urandom_range(7)), $urandom());
                end
                default: mixed_burst();
            endcase
            // Pause the sender after any burst that ends mid-run until the pipe is empty.
            if (sent >= 350 && sent < 380) begin
                wait_drained();
            end
        end

        // Let the last responses arrive before the verdict.
        wait_drained();
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
